/* design/pbpwm_pkg.sv */
// ----------------------------------------------------------------------------
// pbpwm_pkg: shared types and constants
// Widths, timing constants, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbpwm_pkg;

  // Period of the drive waveform in ticks, and the spacing of drive updates.
  localparam int unsigned PERIOD_TICKS  = 10000;
  localparam int unsigned UPDATE_STRIDE = 10;

  localparam int unsigned TEMP_W   = 12;             // temperature sample
  localparam int unsigned THR_W    = 11;             // band thresholds
  localparam int unsigned ON_W     = 14;             // on-time and phase
  localparam int unsigned EXT_W    = 13;             // signed differences
  localparam int unsigned DEN_W    = 11;             // band width magnitude
  localparam int unsigned NUM_W    = DEN_W + ON_W;   // dividend
  localparam int unsigned STRIDE_W = $clog2(UPDATE_STRIDE + 1);
  localparam int unsigned CNT_W    = $clog2(ON_W);   // divider step counter

  typedef enum logic [0:0] {
    REG_LOW  = 1'b0,
    REG_HIGH = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } item_cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the temperature of an accepted sample
    logic setup;     // classify the sample, resolve trivial cases
    logic mult;      // form the dividend
    logic div_step;  // one restoring division step
    logic finish;    // round up and store the on-time
    logic tick;      // advance phase and drive
    logic emit;      // load the output register
  } pbpwm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;     // on-time already known, no division needed
  } pbpwm_sts_t;

endpackage

/* design/pbpwm_ctrl.sv */
// ----------------------------------------------------------------------------
// pbpwm_ctrl: sequencer
// Handles the request handshakes and steps the datapath through each item.
// ----------------------------------------------------------------------------
module pbpwm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pbpwm_pkg::pbpwm_sts_t sts_i,
  output pbpwm_pkg::pbpwm_cmd_t cmd_o
);
  import pbpwm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MULT,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             accept;
  logic             emit_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign emit_ok     = (state_q == ST_EMIT) & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;

  // drop the result once taken; a new one may replace it the same cycle
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (emit_ok) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept & (cmd_i == CMD_SAMPLE);
    cmd_o.tick     = accept & (cmd_i == CMD_TICK);
    cmd_o.setup    = (state_q == ST_SETUP);
    cmd_o.mult     = (state_q == ST_MULT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_FIN);
    cmd_o.emit     = emit_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (cmd_i == CMD_SAMPLE) ? ST_SETUP : ST_EMIT;
          end
        end
        ST_SETUP: begin
          state_q <= sts_i.quick ? ST_EMIT : ST_MULT;
        end
        ST_MULT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ON_W - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/pbpwm_dp.sv */
// ----------------------------------------------------------------------------
// pbpwm_dp: datapath
// Threshold registers, on-time computation with a radix-2 divider,
// phase and drive counters, and the output register.
// ----------------------------------------------------------------------------
module pbpwm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pbpwm_pkg::THR_W-1:0]   cfg_wdata_i,
  input  logic signed [pbpwm_pkg::TEMP_W-1:0] temperature_i,
  input  pbpwm_pkg::pbpwm_cmd_t         cmd_i,
  output pbpwm_pkg::pbpwm_sts_t         sts_o,
  output logic                          drive_on_o,
  output logic [pbpwm_pkg::ON_W-1:0]    on_ticks_o
);
  import pbpwm_pkg::*;

  logic signed [THR_W-1:0]  lo_q, hi_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [ON_W-1:0]          phase_q, on_time_q;
  logic [STRIDE_W-1:0]      stride_q;
  logic                     drive_q;
  logic [DEN_W-1:0]         diff_q, den_q;
  logic [NUM_W-1:0]         work_q;
  logic                     out_drive_q;
  logic [ON_W-1:0]          out_on_q;

  // sample classification
  logic signed [EXT_W-1:0] lo_x, hi_x, t_x, den_s, diff_s, den_m, dpr;
  logic                    zero_band, nonpos, sat, quick;
  logic [ON_W-1:0]         quick_val;

  // divider step
  logic [DEN_W:0]   sh;
  logic             ge;
  logic [DEN_W:0]   sub;
  logic [DEN_W-1:0] rem_n;

  // tick
  logic [ON_W-1:0]     phase_n;
  logic                wrap;
  logic [STRIDE_W-1:0] stride_n;

  always_comb begin
    lo_x   = EXT_W'(lo_q);
    hi_x   = EXT_W'(hi_q);
    t_x    = EXT_W'(temp_q);
    den_s  = hi_x - lo_x;
    diff_s = hi_x - t_x;
    // cooling mode: flip both signs so the band width is positive
    den_m  = den_s[EXT_W-1] ? -den_s  : den_s;
    dpr    = den_s[EXT_W-1] ? -diff_s : diff_s;
    zero_band = (den_s == '0);
    nonpos    = dpr[EXT_W-1] | (dpr == '0);
    sat       = ~nonpos & ($unsigned(dpr) >= $unsigned(den_m));
    quick     = zero_band | nonpos | sat;
    if (zero_band) begin
      quick_val = (t_x < lo_x) ? ON_W'(PERIOD_TICKS) : '0;
    end else if (nonpos) begin
      quick_val = '0;
    end else begin
      quick_val = ON_W'(PERIOD_TICKS);
    end
  end

  assign sts_o.quick = quick;

  always_comb begin
    sh    = {work_q[NUM_W-1:ON_W], work_q[ON_W-1]};
    sub   = sh - {1'b0, den_q};
    ge    = (sh >= {1'b0, den_q});
    rem_n = ge ? sub[DEN_W-1:0] : sh[DEN_W-1:0];
  end

  always_comb begin
    wrap     = (phase_q == ON_W'(PERIOD_TICKS - 1));
    phase_n  = wrap ? '0 : phase_q + 1'b1;
    stride_n = (wrap || stride_q == STRIDE_W'(UPDATE_STRIDE - 1)) ? '0 : stride_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q      <= THR_W'(200);
      hi_q      <= THR_W'(300);
      phase_q   <= '0;
      stride_q  <= '0;
      on_time_q <= '0;
      drive_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOW:  lo_q <= cfg_wdata_i;
          REG_HIGH: hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.setup && quick) begin
        on_time_q <= quick_val;
      end
      if (cmd_i.finish) begin
        // round up when the division left a remainder
        on_time_q <= work_q[ON_W-1:0] + ON_W'(work_q[NUM_W-1:ON_W] != '0);
      end
      if (cmd_i.tick) begin
        phase_q  <= phase_n;
        stride_q <= stride_n;
        if (stride_n == '0) begin
          drive_q <= (phase_n < on_time_q);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      temp_q <= temperature_i;
    end
    if (cmd_i.setup) begin
      diff_q <= dpr[DEN_W-1:0];
      den_q  <= den_m[DEN_W-1:0];
    end
    if (cmd_i.mult) begin
      work_q <= NUM_W'(PERIOD_TICKS) * NUM_W'(diff_q);
    end
    if (cmd_i.div_step) begin
      work_q <= {rem_n, work_q[ON_W-2:0], ge};
    end
    if (cmd_i.emit) begin
      out_drive_q <= drive_q;
      out_on_q    <= on_time_q;
    end
  end

  assign drive_on_o = out_drive_q;
  assign on_ticks_o = out_on_q;

endmodule

/* design/proportional_band_pwm_thermostat_core.sv */
// ----------------------------------------------------------------------------
// proportional_band_pwm_thermostat_core: time-proportional thermostat
// Proportional band controller that drives a heater or cooler with a
// slow PWM waveform.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per item:
//   cmd_i low is a time tick, cmd_i high a temperature sample in tenths.
//   Every request yields exactly one result on the output channel
//   (out_valid_o/out_ready_i): current drive level and on-time in ticks.
//   A tick goes from accept straight to emit. A sample at or beyond the
//   band edges, or with a zero band, is resolved in setup; one inside the
//   band passes through multiply, the 14-step restoring divider (one
//   quotient bit per cycle) and rounding before emit. The next request
//   is taken the cycle after the result is loaded.
//   The output register holds one result; while it is not taken the block
//   still accepts and works on the next request, then waits to emit it.
//   The user must write thresholds through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   only while the block is idle; the block does not enforce it. Reset
//   sets low to 200, high to 300, and clears phase, on-time and drive.
// ----------------------------------------------------------------------------
module proportional_band_pwm_thermostat_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [pbpwm_pkg::THR_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic signed [pbpwm_pkg::TEMP_W-1:0] temperature_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                drive_on_o,
  output logic [pbpwm_pkg::ON_W-1:0]          on_ticks_o
);
  import pbpwm_pkg::*;

  pbpwm_cmd_t cmd;
  pbpwm_sts_t sts;

  // Sequencer: handshakes, item sequencing, divider step count.
  pbpwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: thresholds, on-time divider, phase/drive, output register.
  pbpwm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .temperature_i (temperature_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .drive_on_o    (drive_on_o),
    .on_ticks_o    (on_ticks_o)
  );

endmodule
